// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock, off while reset is low.
`define CHK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed");

// Same check, also active while reset is low.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");

`endif

// ===== sv/fpd_pkg.sv =====
package fpd_pkg;

  localparam int ALT_FRAC_BITS_DEF = 4;
  localparam int POWER_STEPS_DEF   = 16;

  localparam int PW  = 19;   // pressure width
  localparam int AW  = 19;   // altitude / velocity width
  localparam int TBL_LEN = 33;

  localparam logic [PW-1:0] GROUND_RESET = 19'd405300;
  localparam logic [31:0]   INV_EXP_K    = 32'd817310618;
  localparam int ALT_MIN = -16384;
  localparam int ALT_MAX = 262143;

  typedef enum logic [2:0] {
    PH_PAD     = 3'd0,
    PH_ASCENT  = 3'd1,
    PH_APOGEE  = 3'd2,
    PH_DESCENT = 3'd3,
    PH_PROBE   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_LANDED  = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_SQ_MUL,
    S_SQ_UPD,
    S_DIV_HI,
    S_DIV_LO,
    S_DIV_SUM,
    S_POW_MUL,
    S_POW_UPD,
    S_FIN_MUL,
    S_ROUND,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [AW-1:0] alt;
    logic signed [AW-1:0] vel;
    logic signed [AW-1:0] apo;
    phase_e               phase;
  } fpd_res_t;

  typedef logic [32:0] root_tbl_t [TBL_LEN];

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.31, each entry the floor root of the one before.
  function automatic root_tbl_t build_roots();
    root_tbl_t t;
    logic [63:0] tmp;
    t[0] = 33'h1_0000_0000;
    tmp  = isqrt64(64'd1 << 63);
    t[1] = tmp[32:0];
    for (int k = 2; k < TBL_LEN; k++) begin
      tmp  = isqrt64({31'd0, t[k-1]} << 31);
      t[k] = tmp[32:0];
    end
    return t;
  endfunction

  localparam root_tbl_t ROOT_TBL = build_roots();

endpackage

// ===== sv/fpd_mul.sv =====
module fpd_mul (
  input  logic        clk_i,
  input  logic [35:0] a_i,
  input  logic [31:0] b_i,
  output logic [67:0] p_o
);
  logic [67:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 68'(a_i) * 68'(b_i);
  end

  assign p_o = p_q;
endmodule

// ===== sv/fpd_phase.sv =====
module fpd_phase #(
  parameter int ALT_FRAC_BITS = fpd_pkg::ALT_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [fpd_pkg::AW-1:0] alt_i,
  input  logic                        step_i,
  output fpd_pkg::fpd_res_t           res_o
);
  import fpd_pkg::*;

  localparam logic signed [23:0] U = 24'sd1 <<< ALT_FRAC_BITS;

  phase_e                phase_q, phase_d;
  logic signed [AW-1:0]  last_q;
  logic signed [AW-1:0]  apo_q, apo_d;
  logic signed [23:0]    alt, prev, v;
  logic signed [AW-1:0]  vout;

  always_comb begin
    alt     = 24'(alt_i);
    prev    = 24'(last_q);
    v       = alt - prev;
    phase_d = phase_q;
    apo_d   = apo_q;
    case (phase_q)
      PH_PAD:     if (alt > 5 * U && v > 2 * U) phase_d = PH_ASCENT;
      PH_ASCENT:  if (prev > alt && v < 5 * U) begin
        apo_d   = last_q;
        phase_d = PH_APOGEE;
      end
      PH_APOGEE:  if (v < 0 && prev > alt) phase_d = PH_DESCENT;
      PH_DESCENT: if (alt * 5 <= 24'(apo_q) * 4 + 10 * U) phase_d = PH_PROBE;
      PH_PROBE:   if (alt <= 4 * U) phase_d = PH_PAYLOAD;
      PH_PAYLOAD: if (v < U && v > -U && alt < U) phase_d = PH_LANDED;
      default:    phase_d = phase_q;
    endcase
    if (v < -24'sd262144)     vout = AW'(-24'sd262144);
    else if (v > 24'sd262143) vout = AW'(24'sd262143);
    else                      vout = v[AW-1:0];
    res_o.alt   = alt_i;
    res_o.vel   = vout;
    res_o.apo   = apo_d;
    res_o.phase = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PAD;
      last_q  <= '0;
      apo_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      last_q  <= alt_i;
      apo_q   <= apo_d;
    end
  end
endmodule

// ===== sv/flight_phase_detector_core.sv =====
// Barometric altitude and flight phase detector.
// Input stream s_axis: one pressure sample per item (quarter pascals).
// Output stream m_axis: altitude, velocity, apogee and phase per item.
// cfg channel: writes the ground reference pressure; cfg_ready_o is always
// high, and a write takes effect for the next accepted item.
// One item is worked by a sequencer around a single shared multiplier:
// two log2 passes, each a normalise step and POWER_STEPS squaring steps of
// multiply and update; scaling (two partial products by the inverse
// constant, then their sum); POWER_STEPS power product steps of multiply
// and update; then final multiply, rounding and phase update.
// s_axis_tready is high only in idle, so one item is in flight at a time;
// a new item is accepted only once the last has left the sequencer.
// The result sits in an output register; the next item may be accepted
// while it waits. If the receiver stalls, the finished item holds in the
// last sequencer step until the output register frees.
// Reset clears the phase to pad, last altitude and apogee to zero, and
// the ground pressure to 405300.
module flight_phase_detector_core #(
  parameter int ALT_FRAC_BITS = fpd_pkg::ALT_FRAC_BITS_DEF,
  parameter int POWER_STEPS   = fpd_pkg::POWER_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [18:0] pressure_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // altitude, velocity, apogee_height, flight_phase
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [18:0] cfg_data_i
);
  import fpd_pkg::*;

  localparam int CW = $clog2(POWER_STEPS);
  localparam logic [31:0] C_ALT = 32'(44330) << ALT_FRAC_BITS;
  localparam logic [37:0] EIGHT = 38'd8 << 32;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q;
  logic            pass_q;
  logic [PW-1:0]   gp_q, p_q, p0_q;
  logic [31:0]     m_q, acc_q, f_q;
  logic [36:0]     res_q, lp_q, res_nx;
  logic [50:0]     hip_q;
  logic [3:0]      ip_q;
  logic            ddneg_q;
  logic signed [AW-1:0] alt_q;
  logic            out_valid_q;
  logic [63:0]     out_data_q;

  logic [35:0]     mul_a;
  logic [31:0]     mul_b;
  logic [67:0]     prod;
  logic [PW-1:0]   nv;
  logic [4:0]      e;
  logic [32:0]     sq;
  logic [31:0]     m_nx;
  logic [37:0]     d, dmag;
  logic [51:0]     ysum;
  logic [35:0]     ym;
  logic [37:0]     u;
  logic [36:0]     r0, ratio;
  logic [37:0]     dd, ddm;
  logic [68:0]     rsum;
  logic [36:0]     pm;
  logic signed [AW-1:0] alt_nx;
  logic            last_step, step;
  logic [5:0]      tidx;
  fpd_res_t        res;

  fpd_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  fpd_phase #(.ALT_FRAC_BITS(ALT_FRAC_BITS)) u_phase (
    .clk_i(clk_i), .rst_ni(rst_ni), .alt_i(alt_q), .step_i(step), .res_o(res)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign last_step     = (cnt_q == CW'(POWER_STEPS - 1));
  assign tidx          = 6'(cnt_q) + 6'd1;
  assign step          = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    nv = pass_q ? p0_q : p_q;
    e  = '0;
    for (int i = 1; i < PW; i++) begin
      if (nv[i]) e = 5'(i);
    end
    // squaring step of the log2 fraction
    sq     = prod[63:31];
    res_nx = res_q;
    if (sq[32]) begin
      m_nx = sq[32:1];
      res_nx[6'(31 - int'(cnt_q))] = 1'b1;
    end else begin
      m_nx = sq[31:0];
    end
    // log difference and its magnitude
    d    = {1'b0, lp_q} - {1'b0, res_q};
    dmag = d[37] ? -d : d;
    ysum = {1'b0, hip_q} + 52'(prod[45:16]);
    ym   = ysum[51:16];
    u    = d[37] ? EIGHT - 38'(ym) : EIGHT + 38'(ym);
    // ratio = 2^y in Q.32
    r0 = {4'b0, acc_q, 1'b0};
    if (ip_q[3]) ratio = r0 << ip_q[2:0];
    else         ratio = r0 >> (4'd8 - ip_q);
    dd  = (38'd1 << 32) - {1'b0, ratio};
    ddm = dd[37] ? -dd : dd;
    // round to nearest on the magnitude, then saturate
    rsum = {1'b0, prod} + (69'd1 << 31);
    pm   = rsum[68:32];
    if (ddneg_q) begin
      if (pm > 37'(-ALT_MIN)) alt_nx = AW'(ALT_MIN);
      else                    alt_nx = -pm[AW-1:0];
    end else begin
      if (pm > 37'(ALT_MAX)) alt_nx = AW'(ALT_MAX);
      else                   alt_nx = pm[AW-1:0];
    end
  end

  always_comb begin
    mul_a   = {4'b0, m_q};
    mul_b   = m_q;
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (s_axis_tvalid) state_d = S_NORM;
      S_NORM:    state_d = S_SQ_MUL;
      S_SQ_MUL:  state_d = S_SQ_UPD;
      S_SQ_UPD: begin
        if (!last_step)  state_d = S_SQ_MUL;
        else if (!pass_q) state_d = S_NORM;
        else             state_d = S_DIV_HI;
      end
      S_DIV_HI: begin
        mul_a   = 36'(dmag[36:16]);
        mul_b   = INV_EXP_K;
        state_d = S_DIV_LO;
      end
      S_DIV_LO: begin
        mul_a   = 36'(dmag[15:0]);
        mul_b   = INV_EXP_K;
        state_d = S_DIV_SUM;
      end
      S_DIV_SUM: state_d = S_POW_MUL;
      S_POW_MUL: begin
        mul_a   = {4'b0, acc_q};
        mul_b   = ROOT_TBL[tidx][31:0];
        state_d = S_POW_UPD;
      end
      S_POW_UPD: state_d = last_step ? S_FIN_MUL : S_POW_MUL;
      S_FIN_MUL: begin
        mul_a   = ddm[35:0];
        mul_b   = C_ALT;
        state_d = S_ROUND;
      end
      S_ROUND:   state_d = S_DONE;
      S_DONE:    if (step) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gp_q        <= GROUND_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) gp_q <= cfg_data_i;
      if (step) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE:    pass_q <= 1'b0;
        S_NORM:    cnt_q <= '0;
        S_SQ_UPD: begin
          cnt_q <= cnt_q + CW'(1);
          if (last_step) pass_q <= 1'b1;
        end
        S_DIV_SUM: cnt_q <= '0;
        S_POW_UPD: cnt_q <= cnt_q + CW'(1);
        default:   cnt_q <= cnt_q;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (s_axis_tvalid) begin
        // treat zero pressure as one
        p_q  <= (s_axis_tdata[18:0] == '0) ? 19'd1 : s_axis_tdata[18:0];
        p0_q <= (gp_q == '0) ? 19'd1 : gp_q;
      end
      S_NORM: begin
        m_q   <= 32'(nv) << (5'd31 - e);
        res_q <= {e, 32'b0};
      end
      S_SQ_UPD: begin
        m_q   <= m_nx;
        res_q <= res_nx;
        if (last_step && !pass_q) lp_q <= res_nx;
      end
      S_DIV_LO: hip_q <= prod[50:0];
      S_DIV_SUM: begin
        f_q   <= u[31:0];
        ip_q  <= u[35:32];
        acc_q <= 32'h8000_0000;
      end
      S_POW_UPD: if (f_q[5'(31 - int'(cnt_q))]) acc_q <= prod[62:31];
      S_FIN_MUL: ddneg_q <= dd[37];
      S_ROUND:   alt_q <= alt_nx;
      default:   ;
    endcase
    if (step) begin
      out_data_q <= {4'b0, res.phase, res.apo, res.vel, res.alt};
    end
  end
endmodule

// ===== sv/fpd_checker.sv =====
`include "assert_macros.svh"

module fpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  // hold a stalled result
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  // busy right after an accepted item
  `CHK_ASSERT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // pad bits of a result stay zero
  `CHK_ASSERT(a_pad, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[63:60] == 4'd0)
  // no result while reset holds
  `CHK_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |=> !m_axis_tvalid || !$past(rst_ni) == 1'b0)
endmodule

bind flight_phase_detector_core fpd_checker u_fpd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// ===== bench/tb_flight_phase_detector_core.sv =====
`timescale 1ns / 100ps

module tb_flight_phase_detector_core;
  import fpd_pkg::*;

  localparam int FRAC = ALT_FRAC_BITS_DEF;
  localparam int STEPS = POWER_STEPS_DEF;
  localparam int LATENCY = 8 + 6 * STEPS;
  localparam logic [63:0] K_INV = 64'd817310618;

  typedef struct packed {
    logic signed [18:0] alt;
    logic signed [18:0] vel;
    logic signed [18:0] apo;
    logic [2:0]         phase;
  } fix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [18:0] cfg_data_i = '0;

  flight_phase_detector_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [18:0]        gnd_p = 19'd405300;
  logic [2:0]         phase_q = PH_PAD;
  logic signed [31:0] last_alt = 0;
  logic signed [31:0] apo_q = 0;
  logic [63:0]        roots [33];

  fix_t flight_q [$];
  int   errors = 0;
  int   sent = 0;
  int   got = 0;
  int   stall_hold = 0;
  int   phase_seen [7];

  function automatic logic [63:0] sqrt64(logic [63:0] val);
    logic [63:0] v, r, b;
    v = val; r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_fix(logic [18:0] v);
    int e;
    logic [63:0] m, res;
    e = 0;
    while ((v >> e) > 1) e++;
    m = 64'(v) << (31 - e);
    res = 64'(e) << 32;
    for (int k = 1; k <= STEPS; k++) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        res |= 64'd1 << (32 - k);
        m >>= 1;
      end
    end
    return res;
  endfunction

  function automatic logic signed [31:0] pressure_to_alt(logic [18:0] p, logic [18:0] p0);
    logic signed [63:0] d, y, dd, prod;
    logic [63:0] mag, ym, u, f, acc, ratio, pm;
    int n;
    if (p == 0) p = 1;
    if (p0 == 0) p0 = 1;
    d = $signed(log2_fix(p)) - $signed(log2_fix(p0));
    mag = d < 0 ? 64'(-d) : 64'(d);
    ym = (((mag >> 16) * K_INV) + (((mag & 64'hFFFF) * K_INV) >> 16)) >> 16;
    y = d < 0 ? -$signed(ym) : $signed(ym);
    u = 64'(y + (64'sd8 <<< 32));
    n = int'(u >> 32) - 8;
    f = u & 64'hFFFF_FFFF;
    acc = 64'd1 << 31;
    for (int k = 1; k <= STEPS; k++)
      if (f[32-k]) acc = (acc * roots[k]) >> 31;
    ratio = acc << 1;
    if (n >= 0) ratio = ratio << n;
    else ratio = ratio >> (-n);
    dd = $signed(64'd1 << 32) - $signed(ratio);
    prod = dd * 64'sd44330 * (64'sd1 <<< FRAC);
    pm = prod < 0 ? 64'(-prod) : 64'(prod);
    pm = (pm + (64'd1 << 31)) >> 32;
    if (prod < 0) return (pm > 16384) ? ALT_MIN : -$signed(32'(pm));
    return (pm > 64'(ALT_MAX)) ? ALT_MAX : $signed(32'(pm));
  endfunction

  function automatic fix_t advance_flight(logic [18:0] p);
    logic signed [31:0] alt, prev, v, one;
    fix_t r;
    one = 1 <<< FRAC;
    alt = pressure_to_alt(p, gnd_p);
    prev = last_alt;
    v = alt - prev;
    case (phase_q)
      PH_PAD:     if (alt > 5 * one && v > 2 * one) phase_q = PH_ASCENT;
      PH_ASCENT:  if (prev > alt && v < 5 * one) begin
                    apo_q = prev;
                    phase_q = PH_APOGEE;
                  end
      PH_APOGEE:  if (v < 0 && prev > alt) phase_q = PH_DESCENT;
      PH_DESCENT: if (64'(alt) * 5 <= 64'(apo_q) * 4 + 10 * one) phase_q = PH_PROBE;
      PH_PROBE:   if (alt <= 4 * one) phase_q = PH_PAYLOAD;
      PH_PAYLOAD: if (v < one && v > -one && alt < one) phase_q = PH_LANDED;
      default: ;
    endcase
    last_alt = alt;
    r.alt = alt[18:0];
    r.vel = (v < -262144) ? -19'sd262144 : (v > 262143) ? 19'sd262143 : v[18:0];
    r.apo = apo_q[18:0];
    r.phase = phase_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, int idx, int actual, int wanted);
    errors++;
    $display("mismatch item %0d %s: got %0d want %0d", idx, what, actual, wanted);
  endtask

  // receiver: random stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ((got / 97) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fix_t w, a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.alt = m_axis_tdata[18:0];
      a.vel = m_axis_tdata[37:19];
      a.apo = m_axis_tdata[56:38];
      a.phase = m_axis_tdata[59:57];
      if (flight_q.size() == 0) begin
        report_mismatch("unexpected", got, 0, 0);
      end else begin
        w = flight_q.pop_front();
        if (a.alt != w.alt) report_mismatch("altitude", got, a.alt, w.alt);
        if (a.vel != w.vel) report_mismatch("velocity", got, a.vel, w.vel);
        if (a.apo != w.apo) report_mismatch("apogee", got, a.apo, w.apo);
        if (a.phase != w.phase) report_mismatch("phase", got, a.phase, w.phase);
        phase_seen[w.phase]++;
      end
      got <= got + 1;
    end
  end

  int burst_left = 0;

  // valid stays high inside a burst; drop it only for a gap
  task automatic send_sample(logic [18:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 40) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tdata <= {5'd0, p};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    flight_q.push_back(advance_flight(p));
    sent++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (flight_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_ground(logic [18:0] v);
    wait_drain();
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gnd_p = v;
  endtask

  // pressure for a target altitude in metres, near enough for phase shaping
  function automatic logic [18:0] alt_to_p(real m);
    real r;
    r = $pow(1.0 - m / 44330.0, 5.255) * real'(gnd_p);
    if (r < 0.0) r = 0.0;
    if (r > 480000.0) r = 480000.0;
    return 19'($rtoi(r));
  endfunction

  task automatic test_directed();
    logic [18:0] pts [] = '{19'd0, 19'd1, 19'd480000, 19'd405300, 19'd405299,
                            19'd262143, 19'd262144, 19'h7FFFF, 19'd100, 19'd200000};
    foreach (pts[i]) send_sample(pts[i]);
    write_ground(19'd0);
    send_sample(19'd0);
    send_sample(19'd480000);
    write_ground(19'd480000);
    send_sample(19'd1);
    send_sample(19'd480000);
    write_ground(19'd1);
    send_sample(19'd1);
    send_sample(19'd2);
    write_ground(19'h7FFFF);
    send_sample(19'd0);
    write_ground(19'd405300);
  endtask

  // climb, peak, fall, land, with jitter
  task automatic test_flights(int count);
    real peak, a;
    int steps;
    for (int fl = 0; fl < count; fl++) begin
      if ($urandom_range(0, 3) == 0)
        write_ground(19'($urandom_range(300000, 480000)));
      peak = real'($urandom_range(20, 3000));
      steps = $urandom_range(8, 30);
      for (int i = 0; i < 3; i++) send_sample(alt_to_p(real'($urandom_range(0, 1))));
      for (int i = 1; i <= steps; i++) send_sample(alt_to_p(peak * i / steps));
      for (int i = steps; i >= 0; i--) begin
        a = peak * i / steps + real'($urandom_range(0, 2)) - 1.0;
        send_sample(alt_to_p(a < 0 ? 0 : a));
      end
      for (int i = 0; i < 4; i++) send_sample(alt_to_p(0.0));
      if ($urandom_range(0, 2) == 0) send_sample(19'($urandom_range(0, 480000)));
    end
  endtask

  task automatic test_noise(int count);
    for (int i = 0; i < count; i++)
      send_sample($urandom_range(0, 5) == 0 ? 19'($urandom) : 19'($urandom_range(0, 480000)));
  endtask

  task automatic test_backpressure();
    wait_drain();
    stall_hold = 600;
    for (int i = 0; i < 12; i++) send_sample(19'($urandom_range(300000, 480000)));
    wait_drain();
  endtask

  initial begin
    foreach (phase_seen[i]) phase_seen[i] = 0;
    roots[0] = 64'd1 << 32;
    roots[1] = sqrt64(64'd1 << 63);
    for (int k = 2; k < 33; k++) roots[k] = sqrt64(roots[k-1] << 31);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_flights(14);
    test_backpressure();
    test_noise(620);
    wait_drain();
    $display("covered %0d samples, %0d results, ground pressure extremes", sent, got);
    $display("phases reached: pad %0d ascent %0d apogee %0d descent %0d probe %0d",
             phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3], phase_seen[4]);
    if (errors == 0 && flight_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(20 * 2_500_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fpd_pkg.sv
sv/fpd_mul.sv
sv/fpd_phase.sv
sv/flight_phase_detector_core.sv
sv/fpd_checker.sv
bench/tb_flight_phase_detector_core.sv
